### rtl/lpl_pkg.sv
// shared constants, register indexes and control structs of the peak limiter
package lpl_pkg;

   localparam int WINDOW    = 16;
   localparam int TAPS      = 2 * (WINDOW / 2) + 1;
   localparam int WIN_SHIFT = $clog2(WINDOW);

   localparam int SMP_W     = 24;
   localparam int GAIN_W    = 16;
   localparam int THR_W     = 23;
   localparam int HOLD_W    = 16;
   localparam int GAIN_FRAC = 12;
   localparam int GS_W      = 28;
   localparam int MAG_W     = 27;
   localparam int SUM_W     = MAG_W + $clog2(TAPS);
   localparam int AVG_W     = SUM_W - WIN_SHIFT;
   localparam int DEN_W     = AVG_W + 1;
   localparam int PROD_W    = MAG_W + THR_W;
   localparam int NUM_W     = PROD_W + 1;
   localparam int QW        = MAG_W;
   localparam int FILL_W    = $clog2(TAPS + 1);
   localparam int FLUSH_W   = $clog2(TAPS);
   localparam int DIVC_W    = $clog2(QW);
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 23;

   localparam logic [GAIN_W-1:0] GAIN_RESET      = 16'd4096;
   localparam logic [THR_W-1:0]  THRESHOLD_RESET = 23'd8220836;
   localparam logic [HOLD_W-1:0] HOLD_RESET      = 16'd1323;
   localparam logic [HOLD_W-1:0] HOLD_MAX        = '1;

   localparam logic signed [SMP_W-1:0] SMP_MAX = 24'sh7FFFFF;
   localparam logic signed [SMP_W-1:0] SMP_MIN = 24'sh800000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN      = 2'd0,
      CSR_THRESHOLD = 2'd1,
      CSR_HOLD      = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic accept;
      logic scale;
      logic excess;
      logic push;
      logic zero_push;
      logic mult;
      logic load_div;
      logic div_step;
      logic emit;
      logic emit_last;
      logic clear;
   } dp_cmd_type;

   typedef struct packed {
      logic last;
      logic fill_push;
      logic rsp_free;
   } dp_sts_type;

endpackage

### rtl/lookahead_peak_limiter.sv
// top level of the lookahead peak limiter with peak hold
// usage: samples enter on the req_ channel (valid/stall), one beat per sample,
// limited samples leave on the rsp_ channel; csr_ writes gain, threshold and
// hold length, to be used only while the block is idle; the block does not enforce it.
// the first 16 samples of a stream only fill the lookahead line and give no beat;
// from the 17th on, each sample gives one result beat, delayed by 16 samples.
// a sample that gives a result passes through gain, excess and push, one multiply,
// one rounding add, a restoring divider that delivers one quotient bit a cycle and
// one output load; a sample with no result ends after its push. the next sample is
// accepted as soon as the result sits in the output register, so the block takes no
// new sample before it is through with the last one.
// a sample marked last starts a flush: 16 zero pushes give every buffered sample,
// the final beat carries rsp_last_out, and the stream state clears.
// reset (synchronous) restores the registers to unity gain, 0.98 threshold and
// 1323 hold samples and empties the lookahead line; no clearing pass is needed.
// while rsp_stall is high the result beat holds and the sequencer waits before
// loading the next one; req_stall stays high whenever a sample is in progress.
module lookahead_peak_limiter
   import lpl_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_W-1:0]        csr_wr_data,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [SMP_W-1:0] req_sample_in,
   input  logic                    req_last_in,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [SMP_W-1:0] rsp_sample_out,
   output logic                    rsp_last_out
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   lpl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lpl_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .req_sample_in  (req_sample_in),
      .req_last_in    (req_last_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .rsp_last_out   (rsp_last_out),
      .cmd            (cmd),
      .sts            (sts)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("accepted beat did not stall the next one");

   a_div_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load_div |=> cmd.div_step)
      else $error("divider loaded but not stepped");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("result beat lost after emit");

   a_clear_on_final: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> cmd.emit && cmd.emit_last)
      else $error("stream cleared without the final beat");

endmodule

### rtl/lpl_ctrl.sv
// sequencer of the peak limiter: accept, push, divide, emit and flush
module lpl_ctrl
   import lpl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_SCALE  = 8'b0000_0010,
      ST_EXCESS = 8'b0000_0100,
      ST_PUSH   = 8'b0000_1000,
      ST_MULT   = 8'b0001_0000,
      ST_ROUND  = 8'b0010_0000,
      ST_DIV    = 8'b0100_0000,
      ST_EMIT   = 8'b1000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic               flush_ff, flush_in;
   logic               final_ff, final_in;
   logic [FLUSH_W-1:0] flush_cnt_ff, flush_cnt_in;
   logic [DIVC_W-1:0]  div_cnt_ff, div_cnt_in;

   always_comb begin
      state_in     = state_ff;
      flush_in     = flush_ff;
      final_in     = final_ff;
      flush_cnt_in = flush_cnt_ff;
      div_cnt_in   = div_cnt_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept   = 1'b1;
               flush_in     = 1'b0;
               final_in     = 1'b0;
               flush_cnt_in = '0;
               state_in     = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_EXCESS;
         end
         ST_EXCESS: begin
            cmd.excess = 1'b1;
            state_in   = ST_PUSH;
         end
         ST_PUSH: begin
            cmd.push      = 1'b1;
            cmd.zero_push = flush_ff;
            if (flush_ff) begin
               flush_cnt_in = flush_cnt_ff + 1'b1;
               if (flush_cnt_ff == FLUSH_W'(TAPS - 2)) begin
                  final_in = 1'b1;
               end
            end
            if (sts.fill_push) begin
               state_in = ST_MULT;
            end else if (sts.last) begin
               flush_in = 1'b1;
               state_in = ST_PUSH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.load_div = 1'b1;
            div_cnt_in   = DIVC_W'(QW - 1);
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               div_cnt_in = div_cnt_ff - 1'b1;
            end
         end
         ST_EMIT: begin
            if (sts.rsp_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = final_ff;
               if (final_ff) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end else if (sts.last) begin
                  flush_in = 1'b1;
                  state_in = ST_PUSH;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         flush_ff     <= 1'b0;
         final_ff     <= 1'b0;
         flush_cnt_ff <= '0;
         div_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         flush_ff     <= flush_in;
         final_ff     <= final_in;
         flush_cnt_ff <= flush_cnt_in;
         div_cnt_ff   <= div_cnt_in;
      end
   end

endmodule

### rtl/lpl_datapath.sv
// datapath of the peak limiter: gain, peak hold, delay lines, box sum, divider, output register
module lpl_datapath
   import lpl_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_W-1:0]        csr_wr_data,
   input  logic signed [SMP_W-1:0] req_sample_in,
   input  logic                    req_last_in,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [SMP_W-1:0] rsp_sample_out,
   output logic                    rsp_last_out,
   input  dp_cmd_type              cmd,
   output dp_sts_type              sts
);

   logic [GAIN_W-1:0] gain_ff;
   logic [THR_W-1:0]  thr_ff;
   logic [HOLD_W-1:0] hold_lim_ff;

   logic signed [SMP_W-1:0] smp_ff;
   logic                    last_ff;
   logic signed [GS_W-1:0]  gained_ff, gained_in;
   logic [MAG_W-1:0]        over_ff, over_in;

   logic signed [GS_W-1:0]  sdl_ff [TAPS];
   logic [MAG_W-1:0]        edl_ff [TAPS];
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [MAG_W-1:0]        held_ff, held_in;
   logic [HOLD_W-1:0]       hcnt_ff, hcnt_in;
   logic [FILL_W-1:0]       fill_ff, fill_in;
   logic [MAG_W-1:0]        push_ex;

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic              neg_ff, zden_ff;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [QW-1:0]     quo_ff, quo_in;

   logic                    rsp_valid_ff;
   logic signed [SMP_W-1:0] rsp_sample_ff, sat_val;
   logic                    rsp_last_ff;

   logic signed [SMP_W+GAIN_W:0] gain_prod;
   logic [GS_W-1:0]              gmag, tmag;
   logic [MAG_W-1:0]             mag_in;
   logic                         reload;
   logic [NUM_W-1:0]             num;
   logic [DEN_W:0]               trial, diff;
   logic                         ge, big;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff     <= GAIN_RESET;
         thr_ff      <= THRESHOLD_RESET;
         hold_lim_ff <= HOLD_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GAIN:      gain_ff     <= csr_wr_data[GAIN_W-1:0];
            CSR_THRESHOLD: thr_ff      <= csr_wr_data[THR_W-1:0];
            CSR_HOLD:      hold_lim_ff <= csr_wr_data[HOLD_W-1:0];
            default:       ;
         endcase
      end
   end

   // gain and excess
   assign gain_prod = smp_ff * $signed({1'b0, gain_ff});
   assign gained_in = gain_prod[GAIN_FRAC +: GS_W];
   assign gmag      = gained_ff[GS_W-1] ? GS_W'(-gained_ff) : GS_W'(gained_ff);
   assign mag_in    = gmag[MAG_W-1:0];
   assign over_in   = (mag_in > MAG_W'(thr_ff)) ? mag_in - MAG_W'(thr_ff) : '0;

   // peak hold and box sum
   always_comb begin
      reload  = (over_ff > held_ff) || (hcnt_ff > hold_lim_ff);
      held_in = held_ff;
      hcnt_in = hcnt_ff;
      if (reload) begin
         held_in = over_ff;
         hcnt_in = HOLD_W'(1);
      end else if (hcnt_ff != HOLD_MAX) begin
         hcnt_in = hcnt_ff + 1'b1;
      end
      push_ex = cmd.zero_push ? '0 : held_in;
      sum_in  = sum_ff + SUM_W'(push_ex) - SUM_W'(edl_ff[TAPS-1]);
      fill_in = (fill_ff != FILL_W'(TAPS)) ? fill_ff + 1'b1 : fill_ff;
   end

   // scaling of the delayed sample
   assign tmag    = sdl_ff[TAPS-1][GS_W-1] ? GS_W'(-sdl_ff[TAPS-1]) : GS_W'(sdl_ff[TAPS-1]);
   assign prod_in = tmag[MAG_W-1:0] * thr_ff;
   assign den_in  = DEN_W'(sum_ff >> WIN_SHIFT) + DEN_W'(thr_ff);
   assign num     = NUM_W'(prod_ff) + NUM_W'(den_ff >> 1);

   // restoring divider, one quotient bit a cycle
   assign trial = {rem_ff, quo_ff[QW-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      if (cmd.load_div) begin
         rem_in = DEN_W'(num[NUM_W-1:QW]);
         quo_in = num[QW-1:0];
      end else begin
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[QW-2:0], ge};
      end
   end

   // sign and saturation
   always_comb begin
      big = |quo_ff[QW-1:SMP_W-1];
      if (zden_ff) begin
         sat_val = '0;
      end else if (neg_ff) begin
         sat_val = big ? SMP_MIN : -$signed({1'b0, quo_ff[SMP_W-2:0]});
      end else begin
         sat_val = big ? SMP_MAX : $signed({1'b0, quo_ff[SMP_W-2:0]});
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         smp_ff  <= req_sample_in;
         last_ff <= req_last_in;
      end
      if (cmd.scale) begin
         gained_ff <= gained_in;
      end
      if (cmd.excess) begin
         over_ff <= over_in;
      end
      if (cmd.push) begin
         sdl_ff[0] <= cmd.zero_push ? '0 : gained_ff;
         for (int i = 1; i < TAPS; i++) begin
            sdl_ff[i] <= sdl_ff[i-1];
         end
      end
      if (cmd.mult) begin
         prod_ff <= prod_in;
         den_ff  <= den_in;
         neg_ff  <= sdl_ff[TAPS-1][GS_W-1];
         zden_ff <= (den_in == '0);
      end
      if (cmd.load_div || cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (cmd.emit) begin
         rsp_sample_ff <= sat_val;
         rsp_last_ff   <= cmd.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < TAPS; i++) begin
            edl_ff[i] <= '0;
         end
         sum_ff  <= '0;
         held_ff <= '0;
         hcnt_ff <= '0;
         fill_ff <= '0;
      end else if (cmd.push) begin
         edl_ff[0] <= push_ex;
         for (int i = 1; i < TAPS; i++) begin
            edl_ff[i] <= edl_ff[i-1];
         end
         sum_ff  <= sum_in;
         fill_ff <= fill_in;
         if (!cmd.zero_push) begin
            held_ff <= held_in;
            hcnt_ff <= hcnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign sts.last      = last_ff;
   assign sts.fill_push = (fill_ff >= FILL_W'(TAPS - 1));
   assign sts.rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_last_out   = rsp_last_ff;

endmodule

### verif/lookahead_peak_limiter_test.sv
// self-checking testbench for the lookahead peak limiter, random streams against a beat predictor
module lookahead_peak_limiter_test;
   import lpl_pkg::*;

   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int SETTLE_CYCLES = 64;
   localparam int RANDOM_ITEMS  = 280;

   typedef struct packed {
      logic signed [SMP_W-1:0] sample_out;
      logic                    last_out;
   } limited_beat_type;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_pattern_type;

   logic                    clock;
   logic                    reset;
   logic                    csr_wr_en;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_W-1:0]        csr_wr_data;
   logic                    req_valid;
   logic                    req_stall;
   logic signed [SMP_W-1:0] req_sample_in;
   logic                    req_last_in;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [SMP_W-1:0] rsp_sample_out;
   logic                    rsp_last_out;

   // predictor copy of the registers and stream state
   logic [GAIN_W-1:0]       limit_gain;
   logic [THR_W-1:0]        limit_threshold;
   logic [HOLD_W-1:0]       limit_hold;
   logic signed [GS_W-1:0]  gained_line [TAPS];
   logic [MAG_W-1:0]        peak_line [TAPS];
   longint unsigned         peak_sum;
   logic [MAG_W-1:0]        held_excess;
   logic [HOLD_W-1:0]       hold_age;
   int                      line_fill;

   limited_beat_type        expected_beats [$];
   int                      failures = 0;
   int                      burst_left = 0;
   int                      cycle_count;
   stall_pattern_type       stall_pattern = STALL_NONE;
   int                      stall_left = 0;

   lookahead_peak_limiter dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .req_last_in    (req_last_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .rsp_last_out   (rsp_last_out)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic void clear_line();
      foreach (gained_line[k]) begin
         gained_line[k] = '0;
         peak_line[k] = '0;
      end
      peak_sum = 0;
      held_excess = '0;
      hold_age = '0;
      line_fill = 0;
   endfunction

   function automatic void shift_line(logic signed [GS_W-1:0] gained, logic [MAG_W-1:0] excess);
      peak_sum -= peak_line[TAPS-1];
      for (int k = TAPS - 1; k > 0; k--) begin
         gained_line[k] = gained_line[k-1];
         peak_line[k] = peak_line[k-1];
      end
      gained_line[0] = gained;
      peak_line[0] = excess;
      peak_sum += excess;
      if (line_fill < TAPS) line_fill++;
   endfunction

   // scale the oldest gained sample by threshold / (average + threshold)
   function automatic void expect_oldest(logic last);
      limited_beat_type beat;
      longint level;
      longint unsigned mag, den, q;
      level = gained_line[TAPS-1];
      mag = (level < 0) ? -level : level;
      den = peak_sum / WINDOW + limit_threshold;
      beat.sample_out = '0;
      if (den != 0) begin
         q = (mag * limit_threshold + den / 2) / den;
         if (level < 0) beat.sample_out = (q >= 64'd8388608) ? SMP_MIN : SMP_W'(-longint'(q));
         else beat.sample_out = (q > 64'd8388607) ? SMP_MAX : SMP_W'(q);
      end
      beat.last_out = last;
      expected_beats.push_back(beat);
   endfunction

   function automatic void predict_limiter(logic signed [SMP_W-1:0] smp, logic last);
      longint prod, mag, over;
      logic signed [GS_W-1:0] gained;
      int pending;
      bit emitted;
      prod = longint'(smp) * longint'(limit_gain);
      gained = GS_W'(prod >>> GAIN_FRAC);
      mag = (gained < 0) ? -longint'(gained) : longint'(gained);
      over = (mag > limit_threshold) ? mag - limit_threshold : 0;
      if (over > held_excess || hold_age > limit_hold) begin
         held_excess = MAG_W'(over);
         hold_age = '0;
      end
      if (hold_age != HOLD_MAX) hold_age++;
      shift_line(gained, held_excess);
      emitted = (line_fill == TAPS);
      if (emitted) expect_oldest(1'b0);
      if (last) begin
         // flush with silent entries until every buffered sample is out
         pending = emitted ? TAPS - 1 : line_fill;
         while (pending > 0) begin
            shift_line('0, '0);
            if (line_fill == TAPS) begin
               pending--;
               expect_oldest(pending == 0);
            end
         end
         clear_line();
      end
   endfunction

   function automatic logic signed [SMP_W-1:0] pick_sample();
      longint level, span, v;
      case ($urandom_range(0, 9))
         0, 1, 2: v = longint'($urandom_range(0, 16777215)) - 8388608;
         3: v = longint'($urandom_range(0, 512)) - 256;
         4: begin
            case ($urandom_range(0, 3))
               0: v = SMP_MAX;
               1: v = SMP_MIN;
               2: v = 0;
               default: v = -1;
            endcase
         end
         default: begin
            // around the level where the gained sample meets the threshold
            level = (limit_gain == 0) ? longint'(SMP_MAX)
                  : (longint'(limit_threshold) << GAIN_FRAC) / longint'(limit_gain);
            if (level > SMP_MAX) level = SMP_MAX;
            span = level / 4 + 16;
            v = level - span + longint'($urandom_range(0, 32'(2 * span)));
            if (v > SMP_MAX) v = SMP_MAX;
            if (v < 0) v = 0;
            if ($urandom_range(0, 1) == 1) v = -v;
         end
      endcase
      return SMP_W'(v);
   endfunction

   task automatic send_sample(logic signed [SMP_W-1:0] smp, logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_sample_in <= smp;
      req_last_in <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_limiter(smp, last);
      @(negedge clock);
   endtask

   task automatic settle_idle();
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      case (idx)
         CSR_GAIN:      limit_gain = value[GAIN_W-1:0];
         CSR_THRESHOLD: limit_threshold = value[THR_W-1:0];
         CSR_HOLD:      limit_hold = value[HOLD_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_limits(logic [GAIN_W-1:0] g, logic [THR_W-1:0] t, logic [HOLD_W-1:0] h);
      settle_idle();
      write_csr(CSR_GAIN, CSR_W'(g));
      write_csr(CSR_THRESHOLD, CSR_W'(t));
      write_csr(CSR_HOLD, CSR_W'(h));
   endtask

   task automatic random_limits();
      logic [GAIN_W-1:0] g;
      logic [THR_W-1:0] t;
      logic [HOLD_W-1:0] h;
      case ($urandom_range(0, 9))
         0: g = '0;
         1: g = '1;
         2: g = GAIN_RESET;
         3: g = GAIN_W'($urandom_range(1, 65535));
         default: g = GAIN_W'($urandom_range(2048, 16384));
      endcase
      case ($urandom_range(0, 7))
         0: t = '1;
         1: t = '0;
         2: t = THRESHOLD_RESET;
         3, 4: t = THR_W'($urandom);
         default: t = THR_W'($urandom_range(1048576, 8388607));
      endcase
      case ($urandom_range(0, 5))
         0: h = '1;
         1: h = HOLD_RESET;
         2: h = '0;
         3: h = HOLD_W'($urandom);
         default: h = HOLD_W'($urandom_range(1, 40));
      endcase
      set_limits(g, t, h);
   endtask

   task automatic play_stream(int len, int pause_at, bit retune);
      for (int k = 0; k < len; k++) begin
         if (k == pause_at && k != 0) begin
            if (retune) random_limits();
            else settle_idle();
         end
         send_sample(pick_sample(), k == len - 1);
      end
   endtask

   task automatic test_single_sample_stream();
      send_sample(SMP_MIN, 1'b1);
   endtask

   task automatic test_sample_extremes();
      logic signed [SMP_W-1:0] extremes [20] = '{
         SMP_MAX, SMP_MIN, 24'sd0, -24'sd1, 24'sd1, SMP_MAX, SMP_MAX, SMP_MIN, SMP_MIN,
         24'sd0, 24'sh400000, -24'sh400000, 24'sd8220836, 24'sd8220837, -24'sd8220837,
         24'sd0, 24'sd0, 24'sd0, 24'sd1, SMP_MAX};
      foreach (extremes[k]) send_sample(extremes[k], k == 19);
   endtask

   task automatic test_register_extremes();
      set_limits('0, '0, '0);
      play_stream($urandom_range(17, 20), 0, 1'b0);
      set_limits('1, '0, '1);
      play_stream($urandom_range(17, 20), 0, 1'b0);
      set_limits('1, '1, '0);
      play_stream($urandom_range(17, 20), 0, 1'b0);
      set_limits(16'd1, 23'd1, 16'd1);
      play_stream($urandom_range(17, 20), 0, 1'b0);
      set_limits(16'd8192, 23'd2097152, 16'd3);
      play_stream($urandom_range(17, 20), 0, 1'b0);
      set_limits(GAIN_RESET, THRESHOLD_RESET, HOLD_RESET);
      play_stream($urandom_range(17, 20), 0, 1'b0);
   endtask

   task automatic test_pause_and_retune();
      play_stream(45, 20, 1'b0);
      play_stream(45, 25, 1'b1);
   endtask

   task automatic test_random_streams();
      int sent;
      int len;
      int pause_at;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 2) == 0) random_limits();
         case ($urandom_range(0, 9))
            0: len = $urandom_range(1, 4);
            1: len = $urandom_range(5, 16);
            2: len = $urandom_range(17, 18);
            default: len = $urandom_range(19, 60);
         endcase
         pause_at = ($urandom_range(0, 4) == 0) ? $urandom_range(1, len) : 0;
         play_stream(len, pause_at, $urandom_range(0, 1) == 1);
         sent += len;
      end
   endtask

   // result side stalls in runs of changing density
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_pattern = stall_pattern_type'($urandom_range(0, 3));
         stall_left = $urandom_range(10, 150);
      end
      stall_left--;
      case (stall_pattern)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 7) == 0);
         STALL_HALF:  rsp_stall <= ($urandom_range(0, 1) == 0);
         default:     rsp_stall <= ($urandom_range(0, 9) != 0);
      endcase
   end

   always @(posedge clock) begin
      limited_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            $error("unexpected beat: sample_out %0d last_out %0b", rsp_sample_out, rsp_last_out);
            failures++;
         end else begin
            want = expected_beats.pop_front();
            if (rsp_sample_out !== want.sample_out) begin
               $error("sample_out: expected %0d, actual %0d", want.sample_out, rsp_sample_out);
               failures++;
            end
            if (rsp_last_out !== want.last_out) begin
               $error("last_out: expected %0b, actual %0b", want.last_out, rsp_last_out);
               failures++;
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample_in = '0;
      req_last_in = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_GAIN;
      csr_wr_data = '0;
      limit_gain = GAIN_RESET;
      limit_threshold = THRESHOLD_RESET;
      limit_hold = HOLD_RESET;
      clear_line();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_single_sample_stream();
      test_sample_extremes();
      test_register_extremes();
      test_pause_and_retune();
      test_random_streams();
      settle_idle();
      if (failures == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

### files.f
rtl/lpl_pkg.sv
rtl/lpl_ctrl.sv
rtl/lpl_datapath.sv
rtl/lookahead_peak_limiter.sv
verif/lookahead_peak_limiter_test.sv
